// ===== rtl/core/pnot_pkg.sv =====
package pnot_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MULQ = 5'b00010,
        S_MULS = 5'b00100,
        S_DIV  = 5'b01000,
        S_EVAL = 5'b10000
    } t_state;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GLISS_EN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLISS_WIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REATT_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REATT_DEC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_ON = 3'd5;

    localparam logic [23:0] THR_RESET = 24'd32768;
    localparam logic [23:0] SAT24     = 24'hFFFFFF;

    localparam logic [4:0] DIV_LAST = 5'd23;

    // Pitch tolerances in Q7.8 semitones; OCT_NOTES and NOTE_MAX are whole note numbers.
    localparam logic signed [16:0] OCT_HALF  = 17'sd1536;
    localparam logic signed [16:0] OCTAVE    = 17'sd3072;
    localparam logic signed [16:0] DRIFT_MAX = 17'sd192;
    localparam logic signed [16:0] TUNE_MAX  = 17'sd102;
    localparam logic [15:0]        HALF_SEMI = 16'd128;
    localparam logic [8:0]         OCT_NOTES = 9'd12;
    localparam logic [7:0]         NOTE_MAX  = 8'd127;

endpackage

// ===== rtl/core/pitch_note_onset_tracker.sv =====
// The sequencer takes each accepted beat through S_MULQ, S_MULS, S_DIV and S_EVAL.
// A new beat is not accepted before the last one is through: a shared 32x16 multiplier runs
// twice and a restoring divider produces one quotient bit per cycle, 24 bits in all.
// The input stays stalled until a finished result has moved to the output register.
// Synchronous active-low reset clears the note state, the sequencer and the
// output valid, and loads the configuration registers with their default values.
module pitch_note_onset_tracker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pnot_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pnot_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_cand_found,
    input  logic [14:0]                    i_cand_pitch,
    input  logic [23:0]                    i_cand_freq,
    input  logic [31:0]                    i_pitch_power,
    input  logic [31:0]                    i_total_power,
    input  logic                           i_debounce_elapsed,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [6:0]                     o_note,
    output logic                           o_note_event,
    output logic [23:0]                    o_freq_out
);
    import pnot_pkg::*;

    t_state r_state, n_state;

    logic        r_gliss_en;
    logic [14:0] r_gliss_win;
    logic [23:0] r_thr;
    logic [15:0] r_decay;
    logic [31:0] r_power_on;
    logic [15:0] r_quality_on;

    logic [6:0]  r_held, r_last_sent;
    logic [14:0] r_prev_pitch;
    logic [31:0] r_prev_power;
    logic [23:0] r_slope;

    logic        r_found, r_deb;
    logic [14:0] r_pitch;
    logic [23:0] r_freq;
    logic [31:0] r_ppow, r_tpow;
    logic        r_drop, r_sat;
    logic [31:0] r_diff;
    logic [47:0] r_prod_q;
    logic [23:0] r_prod_s;
    logic [31:0] r_rem;
    logic [23:0] r_nbits;
    logic [23:0] r_quot;
    logic [4:0]  r_cnt;

    logic        r_res_pend;
    logic [6:0]  r_res_note;
    logic        r_res_event;
    logic [23:0] r_res_freq;
    logic        r_out_valid;
    logic [6:0]  r_out_note;
    logic        r_out_event;
    logic [23:0] r_out_freq;

    logic        in_acc, out_load;
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    logic [32:0] div_t;
    logic        div_ge;

    logic signed [16:0] err_held, err_fold;
    logic        keep_pitch;
    logic [23:0] ratio;
    logic [24:0] growth_sum;
    logic [23:0] growth;
    logic [6:0]  held1;
    logic [23:0] slope1;
    logic signed [17:0] p_s, win_lo, win_hi;
    logic        gliss_ok, on_ok;
    logic [15:0] p_round;
    logic [7:0]  ip;
    logic signed [16:0] err_ip;
    logic        in_tune;
    logic [8:0]  ip_ext, ls_ext;
    logic        event_ok;
    logic [6:0]  held2, last2;
    logic [23:0] slope2;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = r_res_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE) || r_res_pend;

    assign o_out_valid  = r_out_valid;
    assign o_note       = r_out_note;
    assign o_note_event = r_out_event;
    assign o_freq_out   = r_out_freq;

    always_comb begin
        if (r_state == S_MULQ) begin
            mul_a = r_tpow;
            mul_b = r_quality_on;
        end else begin
            mul_a = {8'd0, r_slope};
            mul_b = r_decay;
        end
        mul_p = mul_a * mul_b;
    end

    assign div_t  = {r_rem, r_nbits[23]};
    assign div_ge = div_t >= {1'b0, r_prev_power};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_MULQ;
            S_MULQ: n_state = S_MULS;
            S_MULS: n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_EVAL;
            S_EVAL: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        err_held = $signed({2'b00, r_pitch}) - $signed({2'b00, r_held, 8'd0});
        if (err_held > OCT_HALF) begin
            err_fold = err_held - OCTAVE;
        end else if (err_held < -OCT_HALF) begin
            err_fold = err_held + OCTAVE;
        end else begin
            err_fold = err_held;
        end
        keep_pitch = (err_fold <= DRIFT_MAX) && (err_fold >= -DRIFT_MAX);

        if (r_prev_power == '0) begin
            ratio = '0;
        end else if (r_sat) begin
            ratio = SAT24;
        end else begin
            ratio = r_quot;
        end
        growth_sum = {1'b0, r_prod_s} + {1'b0, ratio};
        growth = growth_sum[24] ? SAT24 : growth_sum[23:0];

        held1  = r_held;
        slope1 = r_slope;
        if (r_held != '0) begin
            if (!keep_pitch) held1 = '0;
            if (r_drop) begin
                slope1 = '0;
            end else begin
                slope1 = growth;
                if (growth >= r_thr) held1 = '0;
            end
        end

        p_s    = $signed({3'b000, r_pitch});
        win_lo = $signed({3'b000, r_prev_pitch}) - $signed({3'b000, r_gliss_win});
        win_hi = $signed({3'b000, r_prev_pitch}) + $signed({3'b000, r_gliss_win});
        gliss_ok = !r_gliss_en || ((p_s >= win_lo) && (p_s <= win_hi));
        on_ok = (held1 == '0) && r_found && (r_ppow > r_power_on)
                && ({r_ppow, 16'd0} > r_prod_q) && gliss_ok;

        p_round = {1'b0, r_pitch} + HALF_SEMI;
        ip      = p_round[15:8];
        err_ip  = $signed({2'b00, r_pitch}) - $signed({1'b0, ip, 8'd0});
        in_tune = (ip <= NOTE_MAX) && (err_ip <= TUNE_MAX) && (err_ip >= -TUNE_MAX);

        ip_ext = {1'b0, ip};
        ls_ext = {2'b00, r_last_sent};
        event_ok = r_deb || ((ip_ext != ls_ext) && (ip_ext != ls_ext + OCT_NOTES)
                   && (ip_ext + OCT_NOTES != ls_ext));

        held2  = held1;
        last2  = r_last_sent;
        slope2 = slope1;
        if (on_ok && in_tune) begin
            held2 = ip[6:0];
            if (event_ok) begin
                last2  = ip[6:0];
                slope2 = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gliss_en   <= 1'b0;
            r_gliss_win  <= '0;
            r_thr        <= THR_RESET;
            r_decay      <= '0;
            r_power_on   <= '0;
            r_quality_on <= '0;
            r_held       <= '0;
            r_last_sent  <= '0;
            r_prev_pitch <= '0;
            r_prev_power <= '0;
            r_slope      <= '0;
            r_res_pend   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GLISS_EN:   r_gliss_en   <= i_cfg_data[0];
                    CFG_GLISS_WIN:  r_gliss_win  <= i_cfg_data[14:0];
                    CFG_REATT_THR:  r_thr        <= i_cfg_data[23:0];
                    CFG_REATT_DEC:  r_decay      <= i_cfg_data[15:0];
                    CFG_POWER_ON:   r_power_on   <= i_cfg_data;
                    CFG_QUALITY_ON: r_quality_on <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (r_state == S_EVAL) begin
                r_held       <= held2;
                r_last_sent  <= last2;
                r_slope      <= slope2;
                r_prev_pitch <= r_pitch;
                r_prev_power <= r_tpow;
                r_res_pend   <= 1'b1;
            end else if (out_load) begin
                r_res_pend <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_found <= i_cand_found;
            r_deb   <= i_debounce_elapsed;
            r_pitch <= i_cand_found ? i_cand_pitch : '0;
            r_freq  <= i_cand_found ? i_cand_freq : '0;
            r_ppow  <= i_pitch_power;
            r_tpow  <= i_total_power;
            r_drop  <= r_prev_power > i_total_power;
            r_diff  <= i_total_power - r_prev_power;
        end

        if (r_state == S_MULQ) begin
            r_prod_q <= mul_p;
            r_sat    <= {8'd0, r_diff} >= {r_prev_power, 8'd0};
        end

        if (r_state == S_MULS) begin
            r_prod_s <= mul_p[39:16];
            r_rem    <= {8'd0, r_diff[31:8]};
            r_nbits  <= {r_diff[7:0], 16'd0};
            r_quot   <= '0;
            r_cnt    <= DIV_LAST;
        end

        if (r_state == S_DIV) begin
            r_rem   <= div_ge ? 32'(div_t - {1'b0, r_prev_power}) : div_t[31:0];
            r_nbits <= {r_nbits[22:0], 1'b0};
            r_quot  <= {r_quot[22:0], div_ge};
            r_cnt   <= r_cnt - 5'd1;
        end

        if (r_state == S_EVAL) begin
            r_res_note  <= held2;
            r_res_event <= on_ok && in_tune && event_ok;
            r_res_freq  <= r_freq;
        end

        if (out_load) begin
            r_out_note  <= r_res_note;
            r_out_event <= r_res_event;
            r_out_freq  <= r_res_freq;
        end
    end

endmodule

// ===== rtl/core/pnot_checker.sv =====
module pnot_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [6:0]  o_note,
    input logic        o_note_event,
    input logic [23:0] o_freq_out
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a beat");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after its beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_note)
            && $stable(o_note_event) && $stable(o_freq_out))
        else $error("stalled result changed");

endmodule

bind pitch_note_onset_tracker pnot_checker u_pnot_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRIFT_LIMIT = int'(pnot_pkg::DRIFT_MAX);
    localparam int FOLD_LIMIT  = int'(pnot_pkg::OCT_HALF);
    localparam int OCTAVE_Q8   = int'(pnot_pkg::OCTAVE);
    localparam int TUNE_LIMIT  = int'(pnot_pkg::TUNE_MAX);
    localparam int HALF_Q8     = int'(pnot_pkg::HALF_SEMI);
    localparam int TOP_NOTE    = int'(pnot_pkg::NOTE_MAX);
    localparam int OCT_STEP    = int'(pnot_pkg::OCT_NOTES);
    localparam longint unsigned SAT_Q16 = 64'(pnot_pkg::SAT24);
    localparam longint unsigned POWER_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic        found;
        logic [14:0] pitch;
        logic [23:0] freq;
        logic [31:0] pitch_pwr;
        logic [31:0] total_pwr;
        logic        debounce;
    } t_frame;

    typedef struct {
        logic [6:0]  note;
        logic        note_evt;
        logic [23:0] freq;
    } t_note_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [pnot_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [pnot_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic                             i_cand_found = 1'b0;
    logic [14:0]                      i_cand_pitch = '0;
    logic [23:0]                      i_cand_freq = '0;
    logic [31:0]                      i_pitch_power = '0;
    logic [31:0]                      i_total_power = '0;
    logic                             i_debounce_elapsed = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [6:0]                       o_note;
    logic                             o_note_event;
    logic [23:0]                      o_freq_out;

    // Register values mirrored from the configuration writes.
    logic        gliss_on = 1'b0;
    logic [14:0] gliss_span = '0;
    logic [23:0] attack_limit = pnot_pkg::THR_RESET;
    logic [15:0] attack_decay = '0;
    logic [31:0] min_power = '0;
    logic [15:0] min_quality = '0;

    // Tracker state as seen after each accepted frame.
    logic [6:0]  cur_note = '0;
    logic [6:0]  sent_note = '0;
    logic [14:0] last_pitch = '0;
    logic [31:0] prev_frame_pwr = '0;
    logic [23:0] attack_slope = '0;

    t_note_result predicted_notes[$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           hold_left = 0;
    int           tone_note = 60;
    longint unsigned tone_power = 1000;

    pitch_note_onset_tracker u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cand_found       (i_cand_found),
        .i_cand_pitch       (i_cand_pitch),
        .i_cand_freq        (i_cand_freq),
        .i_pitch_power      (i_pitch_power),
        .i_total_power      (i_total_power),
        .i_debounce_elapsed (i_debounce_elapsed),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_note             (o_note),
        .o_note_event       (o_note_event),
        .o_freq_out         (o_freq_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_note_result track_frame(input t_frame f);
        t_note_result    r;
        int              pitch;
        int              drift;
        int              near;
        int              tune_err;
        int              prev_sent;
        longint unsigned tpow;
        longint unsigned ppow;
        longint unsigned growth;
        longint unsigned ratio;
        pitch = f.found ? int'(f.pitch) : 0;
        tpow = f.total_pwr;
        ppow = f.pitch_pwr;
        r.note_evt = 1'b0;
        r.freq = f.found ? f.freq : '0;
        if (cur_note != 0) begin
            drift = pitch - int'(cur_note) * 256;
            if (drift > FOLD_LIMIT) begin
                drift -= OCTAVE_Q8;
            end else if (drift < -FOLD_LIMIT) begin
                drift += OCTAVE_Q8;
            end
            if (drift > DRIFT_LIMIT || drift < -DRIFT_LIMIT) begin
                cur_note = '0;
            end
            if (64'(prev_frame_pwr) > tpow) begin
                attack_slope = '0;
            end else begin
                growth = (64'(attack_slope) * 64'(attack_decay)) >> 16;
                ratio = 0;
                if (prev_frame_pwr != 0) begin
                    ratio = ((tpow - 64'(prev_frame_pwr)) << 16) / 64'(prev_frame_pwr);
                    if (ratio > SAT_Q16) begin
                        ratio = SAT_Q16;
                    end
                end
                growth += ratio;
                if (growth > SAT_Q16) begin
                    growth = SAT_Q16;
                end
                if (growth >= 64'(attack_limit)) begin
                    cur_note = '0;
                end
                attack_slope = growth[23:0];
            end
        end
        prev_frame_pwr = f.total_pwr;
        if (cur_note == 0 && f.found && ppow > 64'(min_power)
                && (ppow << 16) > 64'(min_quality) * tpow
                && (!gliss_on || (pitch >= int'(last_pitch) - int'(gliss_span)
                                  && pitch <= int'(last_pitch) + int'(gliss_span)))) begin
            near = (pitch + HALF_Q8) >>> 8;
            tune_err = pitch - near * 256;
            if (near <= TOP_NOTE && tune_err <= TUNE_LIMIT && tune_err >= -TUNE_LIMIT) begin
                prev_sent = int'(sent_note);
                if (f.debounce || (near != prev_sent && near != prev_sent + OCT_STEP
                                   && near != prev_sent - OCT_STEP)) begin
                    sent_note = 7'(near);
                    attack_slope = '0;
                    r.note_evt = 1'b1;
                end
                cur_note = 7'(near);
            end
        end
        last_pitch = 15'(pitch);
        r.note = cur_note;
        return r;
    endfunction

    function automatic t_frame make_frame(input logic found, input int pitch,
                                          input logic [23:0] freq,
                                          input logic [31:0] ppow,
                                          input logic [31:0] tpow, input logic deb);
        t_frame f;
        f.found = found;
        f.pitch = 15'(pitch);
        f.freq = freq;
        f.pitch_pwr = ppow;
        f.total_pwr = tpow;
        f.debounce = deb;
        return f;
    endfunction

    // Mostly sustained tones with jitter, octave jumps, attacks and drifts;
    // some dropouts and pure noise frames.
    function automatic t_frame random_frame();
        t_frame          f;
        int unsigned     pick;
        int              offset;
        int              pitch;
        longint unsigned tp;
        pick = $urandom_range(0, 99);
        f.found = 1'b1;
        f.freq = 24'($urandom);
        f.debounce = 1'($urandom_range(0, 1));
        if (pick < 8) begin
            f.found = 1'($urandom);
            f.pitch = 15'($urandom);
            f.pitch_pwr = $urandom;
            f.total_pwr = $urandom;
            return f;
        end
        offset = $urandom_range(0, 200) - 100;
        tp = tone_power * $urandom_range(95, 105) / 100;
        if (pick < 16) begin
            f.found = 1'b0;
        end else if (pick < 28) begin
            tone_note = $urandom_range(0, 127);
            tp = ($urandom_range(0, 7) == 0) ? 64'($urandom) : $urandom_range(1, 1 << 20);
        end else if (pick < 36) begin
            if (tone_note >= OCT_STEP && $urandom_range(0, 1) == 1) begin
                tone_note -= OCT_STEP;
            end else if (tone_note + OCT_STEP <= TOP_NOTE) begin
                tone_note += OCT_STEP;
            end
        end else if (pick < 44) begin
            tp = tone_power * $urandom_range(2, 8);
        end else if (pick < 52) begin
            offset = $urandom_range(150, 450);
            if ($urandom_range(0, 1) == 1) begin
                offset = -offset;
            end
        end
        if (tp > POWER_MAX) begin
            tp = POWER_MAX;
        end
        tone_power = tp;
        pitch = tone_note * 256 + offset;
        if (pitch < 0) begin
            pitch = 0;
        end else if (pitch > 32767) begin
            pitch = 32767;
        end
        f.pitch = 15'(pitch);
        f.total_pwr = tp[31:0];
        f.pitch_pwr = 32'(tp * $urandom_range(40, 100) / 100);
        return f;
    endfunction

    task automatic send_frame(input t_frame f);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cand_found <= f.found;
        i_cand_pitch <= f.pitch;
        i_cand_freq <= f.freq;
        i_pitch_power <= f.pitch_pwr;
        i_total_power <= f.total_pwr;
        i_debounce_elapsed <= f.debounce;
        do @(posedge i_clk); while (o_in_stall);
        predicted_notes.push_back(track_frame(f));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (predicted_notes.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pnot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pnot_pkg::CFG_GLISS_EN:   gliss_on = value[0];
            pnot_pkg::CFG_GLISS_WIN:  gliss_span = value[14:0];
            pnot_pkg::CFG_REATT_THR:  attack_limit = value[23:0];
            pnot_pkg::CFG_REATT_DEC:  attack_decay = value[15:0];
            pnot_pkg::CFG_POWER_ON:   min_power = value;
            pnot_pkg::CFG_QUALITY_ON: min_quality = value[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic gl, input logic [14:0] win,
                                  input logic [23:0] thr, input logic [15:0] dec,
                                  input logic [31:0] pwr, input logic [15:0] qual);
        wait_for_results();
        write_reg(pnot_pkg::CFG_GLISS_EN, 32'(gl));
        write_reg(pnot_pkg::CFG_GLISS_WIN, 32'(win));
        write_reg(pnot_pkg::CFG_REATT_THR, 32'(thr));
        write_reg(pnot_pkg::CFG_REATT_DEC, 32'(dec));
        write_reg(pnot_pkg::CFG_POWER_ON, pwr);
        write_reg(pnot_pkg::CFG_QUALITY_ON, 32'(qual));
    endtask

    task automatic apply_random_settings();
        apply_settings(1'($urandom_range(0, 1)),
                       ($urandom_range(0, 3) == 0) ? 15'h7FFF : 15'($urandom_range(0, 600)),
                       ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                   : 24'($urandom_range(8192, 131072)),
                       16'($urandom),
                       32'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 50000)));
    endtask

    task automatic test_note_tracking();
        send_frame(make_frame(1'b0, 32767, 24'hFFFFFF, '1, '1, 1'b1));
        send_frame(make_frame(1'b1, 60 * 256, 24'h0105C0, 1000, 1000, 1'b1));
        send_frame(make_frame(1'b1, 60 * 256 + 100, 24'h0105D0, 900, 1000, 1'b0));
        send_frame(make_frame(1'b1, 72 * 256 + 150, 24'h020B80, 900, 1000, 1'b0));
        send_frame(make_frame(1'b1, 48 * 256 - 190, 24'h0082E0, 900, 1000, 1'b0));
        send_frame(make_frame(1'b1, 60 * 256, 24'h0105C0, 1300, 1400, 1'b0));
        send_frame(make_frame(1'b1, 60 * 256, 24'h0105C0, 2700, 2800, 1'b0));
        send_frame(make_frame(1'b1, 60 * 256 + 193, 24'h011000, 90, 100, 1'b0));
        send_frame(make_frame(1'b0, 0, 24'h000000, 90, 100, 1'b0));
        send_frame(make_frame(1'b1, 73 * 256, 24'h022A00, 90, 100, 1'b0));
        send_frame(make_frame(1'b0, 5000, 24'h123456, 90, 100, 1'b0));
        send_frame(make_frame(1'b1, 49 * 256, 24'h008A00, 90, 100, 1'b0));
        send_frame(make_frame(1'b0, 0, 24'h000000, 90, 100, 1'b0));
        send_frame(make_frame(1'b1, 32767, 24'hFFFFFF, 90, 100, 1'b1));
        send_frame(make_frame(1'b1, 127 * 256 + 102, 24'hC5A000, 90, 100, 1'b0));
        send_frame(make_frame(1'b0, 0, 24'h000000, 90, 100, 1'b0));
        send_frame(make_frame(1'b1, 50 * 256 + 103, 24'h009300, 90, 100, 1'b1));
        send_frame(make_frame(1'b1, 50 * 256 - 103, 24'h009200, 90, 100, 1'b1));
        send_frame(make_frame(1'b1, 50, 24'h000800, 90, 100, 1'b1));
        send_frame(make_frame(1'b1, 0, 24'h000800, 0, 100, 1'b1));
        send_frame(make_frame(1'b1, 64 * 256, 24'h014A00, 1, 1, 1'b1));
        send_frame(make_frame(1'b1, 64 * 256, 24'h014A00, '1, '1, 1'b0));
        send_frame(make_frame(1'b1, 64 * 256, 24'h014A00, 5, 0, 1'b0));
        send_frame(make_frame(1'b1, 64 * 256, 24'h014A00, 5, 0, 1'b0));
    endtask

    task automatic test_register_settings();
        apply_settings(1'b1, 15'd64, 24'hFFFFFF, 16'hFFFF, 32'd500, 16'h8000);
        send_frame(make_frame(1'b0, 0, 24'h0, 900, 1000, 1'b1));
        send_frame(make_frame(1'b1, 40 * 256, 24'h00A500, 1000, 1000, 1'b1));
        send_frame(make_frame(1'b1, 40 * 256 + 50, 24'h00A580, 1000, 1000, 1'b1));
        send_frame(make_frame(1'b1, 40 * 256 + 40, 24'h00A580, 1000, 3000, 1'b0));
        send_frame(make_frame(1'b1, 40 * 256 + 40, 24'h00A580, 1000, 9000, 1'b0));
        apply_settings(1'b1, 15'h7FFF, 24'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
        send_frame(make_frame(1'b1, 30 * 256, 24'h005C00, '1, '1, 1'b1));
        send_frame(make_frame(1'b1, 30 * 256, 24'h005C00, '1, 1, 1'b1));
        apply_settings(1'b0, 15'd0, 24'd0, 16'd0, 32'd0, 16'd0);
        send_frame(make_frame(1'b1, 30 * 256, 24'h005C00, 10, 10, 1'b1));
        send_frame(make_frame(1'b1, 30 * 256, 24'h005C00, 10, 10, 1'b0));
    endtask

    task automatic test_random_frames(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3) begin
            apply_random_settings();
            repeat (43) send_frame(random_frame());
        end
    endtask

    // The receiver holds off long enough for the block to fill up and
    // stall its input while frames keep coming.
    task automatic test_output_hold();
        apply_random_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left <= 300;
        repeat (30) send_frame(random_frame());
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_note_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_notes.size() == 0) begin
                $error("result beat with nothing expected: note %0d", o_note);
                mismatch_count++;
            end else begin
                want = predicted_notes.pop_front();
                if (o_note !== want.note) begin
                    $error("note: expected %0d, got %0d", want.note, o_note);
                    mismatch_count++;
                end
                if (o_note_event !== want.note_evt) begin
                    $error("note_event: expected %0d, got %0d", want.note_evt, o_note_event);
                    mismatch_count++;
                end
                if (o_freq_out !== want.freq) begin
                    $error("freq_out: expected %0h, got %0h", want.freq, o_freq_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 37;
        recv_idle_pct = 65;
        test_note_tracking();
        test_register_settings();
        test_random_frames(37, 65);
        test_random_frames(65, 37);
        test_random_frames(0, 0);
        test_output_hold();
        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
